// ===== hdl/sync_length_xor_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Sync / length / XOR frame receiver - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SXFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sxfr assertion failed");

// next-cycle implication, disabled during reset
`define SXFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sxfr assertion failed");

`endif

// ===== hdl/sxfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sxfr_pkg
// Types and constants of the sync / length / XOR frame receiver.
// ----------------------------------------------------------------------------
package sxfr_pkg;

   localparam logic [7:0] SYNC_BYTE        = 8'hBB;
   localparam logic [7:0] STATUS_TYPE      = 8'h04;
   localparam logic [8:0] STATUS_MIN_BYTES = 9'd40;
   localparam logic [7:0] TYPE_INDEX       = 8'd3;
   localparam logic [7:0] LENGTH_INDEX     = 8'd4;
   localparam logic [8:0] FRAME_OVERHEAD   = 9'd6;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      V_OK         = 3'd0,
      V_BAD_SUM    = 3'd1,
      V_OTHER_TYPE = 3'd2,
      V_SHORT      = 3'd3,
      V_TOO_LONG   = 3'd4
   } verdict_type;

   // one result word as handed from the parser to the output register
   typedef struct packed {
      logic        emit;
      logic [7:0]  frame_byte;
      logic [7:0]  byte_index;
      logic        end_of_frame;
      verdict_type verdict;
   } result_type;

endpackage

// ===== hdl/sxfr_parser.sv =====
// ----------------------------------------------------------------------------
// sxfr_parser
// Frame state machine: sync hunt, header, body and checksum verdict.
// ----------------------------------------------------------------------------
module sxfr_parser #(
   parameter int MAX_FRAME_BYTES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,       // consume rx_byte this cycle
   input  logic [7:0]         rx_byte,
   output sxfr_pkg::result_type result    // valid in the cycle of step
);
   import sxfr_pkg::*;

   localparam logic [8:0] MaxTotal = 9'(MAX_FRAME_BYTES);

   phase_type  phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [8:0] total_ff, total_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] kind_ff, kind_in;
   logic [8:0] len_total;
   logic       last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         total_ff <= '0;
         xor_ff   <= '0;
         kind_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         total_ff <= total_in;
         xor_ff   <= xor_in;
         kind_ff  <= kind_in;
      end
   end

   assign len_total = {1'b0, rx_byte} + FRAME_OVERHEAD;
   assign last_byte = ({1'b0, count_ff} + 9'd1) >= total_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      total_in = total_ff;
      xor_in   = xor_ff;
      kind_in  = kind_ff;

      result.emit         = 1'b1;
      result.frame_byte   = rx_byte;
      result.byte_index   = count_ff;
      result.end_of_frame = 1'b0;
      result.verdict      = V_OK;

      case (phase_ff)
         PH_HEADER: begin
            if (count_ff == TYPE_INDEX) begin
               kind_in = rx_byte;
            end
            xor_in   = xor_ff ^ rx_byte;
            count_in = count_ff + 8'd1;
            if (count_ff == LENGTH_INDEX) begin
               total_in = len_total;
               if (len_total > MaxTotal) begin
                  phase_in            = PH_HUNT;
                  count_in            = '0;
                  result.end_of_frame = 1'b1;
                  result.verdict      = V_TOO_LONG;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (last_byte) begin
               phase_in            = PH_HUNT;
               count_in            = '0;
               result.end_of_frame = 1'b1;
               if (rx_byte != xor_ff) begin
                  result.verdict = V_BAD_SUM;
               end else if (kind_ff != STATUS_TYPE) begin
                  result.verdict = V_OTHER_TYPE;
               end else if (total_ff < STATUS_MIN_BYTES) begin
                  result.verdict = V_SHORT;
               end else begin
                  result.verdict = V_OK;
               end
            end else begin
               xor_in   = xor_ff ^ rx_byte;
               count_in = count_ff + 8'd1;
            end
         end
         default: begin
            // hunting: anything but sync is dropped
            if (rx_byte == SYNC_BYTE) begin
               phase_in = PH_HEADER;
               count_in = 8'd1;
               xor_in   = rx_byte;
               total_in = '0;
               kind_in  = '0;
            end else begin
               result.emit = 1'b0;
            end
         end
      endcase
   end

endmodule

// ===== hdl/sync_length_xor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Length-prefixed frame receiver with XOR checksum and frame verdict.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)             | tlast        | tuser
//  req     | in  | rx_byte[7:0]                   | -            | -
//  rsp     | out | frame_byte[7:0], byte_index[15:8] | end_of_frame | verdict[2:0]
//
//  One byte per cycle while rsp is not stalled; a taken byte goes into the
//  input register, then through the parser into the result register, which
//  drives rsp.
//  Dropped bytes while hunting for sync give no rsp word.
//  A stalled rsp word holds; the parser keeps going as long as its result
//  can move on, so a full rsp register stops req only when the next byte
//  would produce a word.
//  Reset is synchronous, active high, and puts the parser back to hunting.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver #(
   parameter int MAX_FRAME_BYTES = 64   // 40 .. 256, frames above are too long
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,      // [7:0] frame_byte, [15:8] byte_index
   output logic        rsp_tlast,      // end_of_frame
   output logic [2:0]  rsp_tuser       // [2:0] verdict
);
   import sxfr_pkg::*;

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;

   // result register
   logic        out_vld_ff, out_vld_in;
   logic [15:0] out_data_ff;
   logic        out_last_ff;
   logic [2:0]  out_user_ff;

   result_type res;
   logic       out_free;
   logic       step;

   // result register can take a word this cycle
   assign out_free = !out_vld_ff || rsp_tready;
   // a held byte is parsed if its word has room or it makes no word
   assign step       = in_vld_ff && (out_free || !res.emit);
   assign req_tready = !in_vld_ff || step;

   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign out_vld_in = (step && res.emit) || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (step && res.emit) begin
         out_data_ff <= {res.byte_index, res.frame_byte};
         out_last_ff <= res.end_of_frame;
         out_user_ff <= res.verdict;
      end
   end

   sxfr_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (res)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== hdl/sxfr_checker.sv =====
// ----------------------------------------------------------------------------
// sxfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "sync_length_xor_frame_receiver_defines.svh"

module sxfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [2:0]  rsp_tuser
);
   import sxfr_pkg::*;

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata == SYNC_BYTE);

   // a stalled word stays put
   `SXFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // index zero is always the sync byte
   `SXFR_ASSERT_NOW(a_index0_sync, clock, reset, rsp_tvalid && (rsp_tdata[15:8] == 8'd0),
      rsp_tdata[7:0] == SYNC_BYTE)

   // verdict reads zero except on frame end
   `SXFR_ASSERT_NOW(a_verdict_idle, clock, reset, rsp_tvalid && !rsp_tlast,
      rsp_tuser == V_OK)

   // a frame cannot end before its length byte
   `SXFR_ASSERT_NOW(a_end_index, clock, reset, rsp_tvalid && rsp_tlast,
      rsp_tdata[15:8] >= LENGTH_INDEX)

   // too long ends exactly on the length byte
   `SXFR_ASSERT_NOW(a_too_long_at_len, clock, reset,
      rsp_tvalid && rsp_tlast && (rsp_tuser == V_TOO_LONG) && !req_seen,
      rsp_tdata[15:8] == LENGTH_INDEX)

endmodule

bind sync_length_xor_frame_receiver sxfr_checker u_sxfr_checker (.*);

// ===== test/sync_length_xor_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver_tb
// Self-checking bench for the sync / length / XOR frame receiver. A directed
// table hits the header corners (sync inside a frame, the length limit, every
// verdict that is easy to see). Random framed traffic follows, with line
// noise and cut-off frames mixed in. Every rsp word is checked against a
// local frame parser, while the sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver_tb;
   import sxfr_pkg::*;

   localparam int MAX_FRAME = 64;
   localparam int ITEMS = 1150;         // framed bytes to push in total
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;     // pipeline is two deep

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   // one expected rsp word
   typedef struct {
      logic [7:0]  frame_byte;
      logic [7:0]  byte_index;
      logic        end_of_frame;
      verdict_type verdict;
   } frame_word_type;

   // directed row; when typed is set the expectation is the one written here
   typedef struct {
      logic [7:0]  rx;
      bit          typed;
      bit          echoed;
      logic [7:0]  idx;
      bit          eof;
      verdict_type verdict;
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;       // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;               // [7:0] frame_byte, [15:8] byte_index
   logic        rsp_tlast;               // end_of_frame
   logic [2:0]  rsp_tuser;               // [2:0] verdict

   // parser copy kept by the bench
   phase_type   prs_phase = PH_HUNT;
   logic [7:0]  prs_count = '0;
   logic [8:0]  prs_total = '0;
   logic [7:0]  prs_xor = '0;
   logic [7:0]  prs_kind = '0;

   frame_word_type pending_words[$];
   int          mismatches = 0;
   int          framed_bytes = 0;
   int          burst_left = 0;
   bit          gappy = 1'b1;
   rx_mode_type rx_mode = RX_RANDOM;
   int          stall_step = 0;

   sync_length_xor_frame_receiver #(
      .MAX_FRAME_BYTES(MAX_FRAME)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // Frame parser: advances the bench state by one byte, returns 1 when the
   // byte is echoed. Bytes while hunting are dropped unless they are sync.
   function automatic bit parse_rx_byte(input logic [7:0] rx, output frame_word_type w);
      logic [7:0] pos;
      pos = prs_count;
      w.frame_byte   = rx;
      w.byte_index   = pos;
      w.end_of_frame = 1'b0;
      w.verdict      = V_OK;
      if (prs_phase == PH_HUNT) begin
         if (rx != SYNC_BYTE) return 1'b0;
         prs_phase = PH_HEADER;
         prs_count = 8'd1;
         prs_xor   = rx;
         prs_total = '0;
         prs_kind  = '0;
         w.byte_index = 8'd0;
         return 1'b1;
      end
      if (prs_phase == PH_HEADER) begin
         if (pos == TYPE_INDEX) prs_kind = rx;
         prs_xor = prs_xor ^ rx;
         if (pos == LENGTH_INDEX) begin
            prs_total = {1'b0, rx} + FRAME_OVERHEAD;
            if (int'(prs_total) > MAX_FRAME) begin
               // length alone kills the frame, checksum never looked at
               prs_phase = PH_HUNT;
               prs_count = '0;
               w.end_of_frame = 1'b1;
               w.verdict = V_TOO_LONG;
               return 1'b1;
            end
            prs_phase = PH_BODY;
         end
         prs_count = pos + 8'd1;
         return 1'b1;
      end
      // body; the last byte carries the checksum
      if ({1'b0, pos} + 9'd1 >= prs_total) begin
         if (rx != prs_xor) w.verdict = V_BAD_SUM;
         else if (prs_kind != STATUS_TYPE) w.verdict = V_OTHER_TYPE;
         else if (prs_total < STATUS_MIN_BYTES) w.verdict = V_SHORT;
         else w.verdict = V_OK;
         w.end_of_frame = 1'b1;
         prs_phase = PH_HUNT;
         prs_count = '0;
         return 1'b1;
      end
      prs_xor = prs_xor ^ rx;
      prs_count = pos + 8'd1;
      return 1'b1;
   endfunction

   // Push one byte through req. With gappy set the sender runs in bursts.
   // typed_w overrides the parser's word when the row spells it out.
   task automatic push_rx_byte(input logic [7:0] rx, input bit typed, input bit typed_echo,
                               input frame_word_type typed_w);
      frame_word_type w;
      bit echoed;
      if (gappy) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      // inputs here are pre-edge values, so this is the accept condition
      do @(posedge clock); while (!req_tready);
      echoed = parse_rx_byte(rx, w);
      if (typed) begin
         echoed = typed_echo;
         w = typed_w;
      end
      if (echoed) begin
         pending_words.push_back(w);
         framed_bytes++;
      end
   endtask

   // sender stays quiet until every expected word is out
   task automatic wait_all_words;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      stall_step <= (stall_step == 10) ? 0 : stall_step + 1;
      case (rx_mode)
         RX_ALWAYS: rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:   rsp_tready <= (stall_step < 5) || (stall_step == 8);
      endcase
   end

   // rsp checker: each word against the oldest expectation
   always @(posedge clock) begin
      frame_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: byte %h idx %0d last %b verdict %0d",
                        rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast, rsp_tuser);
         end else begin
            w = pending_words.pop_front();
            if (rsp_tdata[7:0] !== w.frame_byte || rsp_tdata[15:8] !== w.byte_index ||
                rsp_tlast !== w.end_of_frame || rsp_tuser !== w.verdict) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h/%0d/%b/%0d got %h/%0d/%b/%0d",
                           w.frame_byte, w.byte_index, w.end_of_frame, w.verdict,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   initial begin : stimulus
      dir_row_type    rows [25];
      frame_word_type tw;
      logic [7:0]     fbuf [0:261];
      logic [7:0]     sum;
      int             plen, flen, nsend, pick;

      rows = '{
         // dropped while hunting
         '{8'h00, 1, 0, 8'd0, 0, V_OK},
         '{8'hFF, 1, 0, 8'd0, 0, V_OK},
         // sync, then sync again as plain data, length 255 is too long
         '{8'hBB, 1, 1, 8'd0, 0, V_OK},
         '{8'hBB, 1, 1, 8'd1, 0, V_OK},
         '{8'h00, 1, 1, 8'd2, 0, V_OK},
         '{8'h04, 1, 1, 8'd3, 0, V_OK},
         '{8'hFF, 1, 1, 8'd4, 1, V_TOO_LONG},
         // empty payload, good sum, type 5
         '{8'hBB, 1, 1, 8'd0, 0, V_OK},
         '{8'h01, 0, 0, 8'd0, 0, V_OK},
         '{8'h02, 0, 0, 8'd0, 0, V_OK},
         '{8'h05, 0, 0, 8'd0, 0, V_OK},
         '{8'h00, 0, 0, 8'd0, 0, V_OK},
         '{8'hBD, 1, 1, 8'd5, 1, V_OTHER_TYPE},
         // status type, empty payload, wrong sum (BF expected)
         '{8'hBB, 1, 1, 8'd0, 0, V_OK},
         '{8'h00, 0, 0, 8'd0, 0, V_OK},
         '{8'h00, 0, 0, 8'd0, 0, V_OK},
         '{8'h04, 0, 0, 8'd0, 0, V_OK},
         '{8'h00, 0, 0, 8'd0, 0, V_OK},
         '{8'h00, 1, 1, 8'd5, 1, V_BAD_SUM},
         // one past the buffer size
         '{8'hBB, 1, 1, 8'd0, 0, V_OK},
         '{8'h55, 0, 0, 8'd0, 0, V_OK},
         '{8'hAA, 0, 0, 8'd0, 0, V_OK},
         '{8'h04, 0, 0, 8'd0, 0, V_OK},
         '{8'd59, 1, 1, 8'd4, 1, V_TOO_LONG},
         // back to hunting
         '{8'h7F, 1, 0, 8'd0, 0, V_OK}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         tw.frame_byte   = rows[i].rx;
         tw.byte_index   = rows[i].idx;
         tw.end_of_frame = rows[i].eof;
         tw.verdict      = rows[i].verdict;
         push_rx_byte(rows[i].rx, rows[i].typed, rows[i].echoed, tw);
      end
      wait_all_words();

      // random frames, mostly well formed, some noise and cut-off frames
      while (framed_bytes < ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            gappy   = $urandom_range(0, 1);
            rx_mode = rx_mode_type'($urandom_range(0, 2));
         end
         if ($urandom_range(0, 11) == 0) wait_all_words();
         if ($urandom_range(0, 7) == 0) begin
            // line noise, never sync
            repeat ($urandom_range(1, 4)) begin
               pick = $urandom_range(0, 255);
               push_rx_byte((pick == SYNC_BYTE) ? 8'h3C : pick[7:0], 0, 0, tw);
            end
         end else begin
            pick = $urandom_range(0, 19);
            if (pick < 11) plen = $urandom_range(0, 33);
            else if (pick < 17) plen = $urandom_range(34, MAX_FRAME - 7);
            else if (pick == 17) plen = MAX_FRAME - 6;      // exactly the buffer
            else plen = $urandom_range(MAX_FRAME - 5, 255);  // too long
            flen = plen + 6;
            fbuf[0] = SYNC_BYTE;
            fbuf[1] = 8'($urandom);
            fbuf[2] = 8'($urandom);
            fbuf[3] = ($urandom_range(0, 1) != 0) ? STATUS_TYPE : 8'($urandom);
            fbuf[4] = plen[7:0];
            sum = fbuf[0] ^ fbuf[1] ^ fbuf[2] ^ fbuf[3] ^ fbuf[4];
            for (int k = 5; k < flen - 1; k++) begin
               fbuf[k] = 8'($urandom);
               sum = sum ^ fbuf[k];
            end
            fbuf[flen - 1] = ($urandom_range(0, 3) == 0) ?
                             sum ^ 8'($urandom_range(1, 255)) : sum;
            nsend = (flen > MAX_FRAME) ? 5 : flen;
            // a cut-off frame: the next sync lands inside it as data
            if ($urandom_range(0, 15) == 0) nsend = $urandom_range(1, nsend - 1);
            for (int k = 0; k < nsend; k++) push_rx_byte(fbuf[k], 0, 0, tw);
         end
      end

      wait_all_words();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sync_length_xor_frame_receiver.f =====
+incdir+hdl
hdl/sxfr_pkg.sv
hdl/sxfr_parser.sv
hdl/sync_length_xor_frame_receiver.sv
hdl/sxfr_checker.sv
test/sync_length_xor_frame_receiver_tb.sv
